// File: design/pwad_pkg.sv
`default_nettype none

package pwad_pkg;

    // Field and register widths.
    localparam int SAMP_W     = 16;
    localparam int GAIN_W     = 24;
    localparam int SGAIN_W    = GAIN_W + 1;
    localparam int ERR_W      = SAMP_W + 1;
    localparam int CHG_W      = ERR_W + 1;
    localparam int P_PROD_W   = SGAIN_W + ERR_W;
    localparam int C_PROD_W   = SGAIN_W + CHG_W;
    localparam int INC_W      = C_PROD_W + 1;
    localparam int INTEG_W    = 34;
    localparam int SUM_W      = INC_W + 1;
    localparam int CLAMP_W    = 64;
    localparam int FRAC_W     = 16;
    localparam int ROUND_W    = 2 * SAMP_W + 1;
    localparam int ROUND_HALF = 32768;
    localparam int NSTG       = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic signed [SAMP_W-1:0] OUT_MIN_RST = -16'sd255;
    localparam logic signed [SAMP_W-1:0] OUT_MAX_RST = 16'sd255;

    typedef logic signed [SAMP_W-1:0] t_sample;
    typedef logic signed [CHG_W-1:0]  t_change;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP      = 3'd0,
        CFG_KI      = 3'd1,
        CFG_KD      = 3'd2,
        CFG_P_ERR   = 3'd3,
        CFG_REVERSE = 3'd4,
        CFG_OUT_MIN = 3'd5,
        CFG_OUT_MAX = 3'd6,
        CFG_AUTO    = 3'd7
    } t_cfg_idx;

    // Controls of one history cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    // Stage loads of the constant divider.
    typedef struct packed {
        logic load_a;
        logic load_b;
    } t_div_ctl;

    // Gain with the process direction applied.
    function automatic logic signed [SGAIN_W-1:0] signed_gain(
        input logic [GAIN_W-1:0] gain,
        input logic              reverse
    );
        logic signed [SGAIN_W-1:0] s;
        s = $signed({1'b0, gain});
        return reverse ? -s : s;
    endfunction

    // Clamp a Q.16 value to integer limits; the upper limit is tested first.
    function automatic logic signed [CLAMP_W-1:0] clamp_q16(
        input logic signed [CLAMP_W-1:0] x,
        input t_sample                   lo,
        input t_sample                   hi
    );
        logic signed [CLAMP_W-1:0] hq;
        logic signed [CLAMP_W-1:0] lq;
        hq = {{(CLAMP_W - SAMP_W - FRAC_W){hi[SAMP_W-1]}}, hi, {FRAC_W{1'b0}}};
        lq = {{(CLAMP_W - SAMP_W - FRAC_W){lo[SAMP_W-1]}}, lo, {FRAC_W{1'b0}}};
        if (x > hq) begin
            return hq;
        end else if (x < lq) begin
            return lq;
        end
        return x;
    endfunction

endpackage

`default_nettype wire

// File: design/pwad_ifs.sv
`default_nettype none

interface pwad_in_if;
    logic                valid;
    logic                ready;
    pwad_pkg::t_sample   setpoint;
    pwad_pkg::t_sample   measured;

    modport source(output valid, output setpoint, output measured, input ready);
    modport sink(input valid, input setpoint, input measured, output ready);
endinterface

interface pwad_out_if;
    logic                valid;
    logic                ready;
    pwad_pkg::t_sample   drive;
    logic                computed;

    modport source(output valid, output drive, output computed, input ready);
    modport sink(input valid, input drive, input computed, output ready);
endinterface

interface pwad_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pwad_pkg::CFG_IDX_W-1:0]    index;
    logic [pwad_pkg::CFG_DATA_W-1:0]   data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/pwad_hcell.sv
`default_nettype none

module pwad_hcell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pwad_pkg::t_cell_ctl i_ctl,
    input  wire pwad_pkg::t_change   i_d,
    output pwad_pkg::t_change        o_q
);

    pwad_pkg::t_change r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_ctl.clear) begin
            r_q <= '0;
        end else if (i_ctl.shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// File: design/pwad_fdiv.sv
`default_nettype none

// Two-stage floor division by a constant: a reciprocal multiply that lands
// within one of the quotient, then one remainder check that fixes it.
module pwad_fdiv #(
    parameter int XW  = 21,
    parameter int DIV = 8
) (
    input  wire logic                   i_clk,
    input  wire pwad_pkg::t_div_ctl     i_ctl,
    input  wire logic signed [XW-1:0]   i_x,
    output logic signed [XW-1:0]        o_q,
    output logic [$clog2(DIV)-1:0]      o_r
);

    localparam int RW = $clog2(DIV);
    localparam int MW = XW + 1;
    localparam int EW = XW + 8;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << XW) / 64'(DIV) + 64'd1);
    localparam logic signed [EW-1:0] DIV_E = EW'(DIV);

    logic signed [XW+MW-1:0] prod;
    logic signed [XW-1:0]    r_q0;
    logic signed [XW-1:0]    r_xd;
    logic signed [EW-1:0]    rem;
    logic signed [EW-1:0]    rem_adj;
    logic                    lo;
    logic                    hi;
    logic signed [XW-1:0]    r_q;
    logic [RW-1:0]           r_r;

    assign prod = i_x * $signed(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_a) begin
            r_q0 <= prod[XW +: XW];
            r_xd <= i_x;
        end
    end

    always_comb begin
        rem = EW'(r_xd) - EW'(r_q0) * DIV_E;
        lo  = rem[EW-1];
        hi  = !lo && (rem >= DIV_E);
        if (lo) begin
            rem_adj = rem + DIV_E;
        end else if (hi) begin
            rem_adj = rem - DIV_E;
        end else begin
            rem_adj = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_b) begin
            r_q <= r_q0 + XW'(hi) - XW'(lo);
            r_r <= rem_adj[RW-1:0];
        end
    end

    assign o_q = r_q;
    assign o_r = r_r;

endmodule

`default_nettype wire

// File: design/pid_with_averaged_derivative.sv
// Throughput: one word per cycle; each of the 8 stages stalls only when the
// stage after it is full, so a bubble lets a new word in behind a held result.
// The integral loop closes in a single stage, which is what sets that rate.
// Reset: registers return to their reset values, controller state is zero and
// the pipeline is empty; no clearing pass is needed.
`default_nettype none

module pid_with_averaged_derivative #(
    parameter int VEL_WINDOW = 8
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    pwad_in_if.sink       i_in,
    pwad_cfg_if.sink      i_cfg,
    pwad_out_if.source    o_out
);

    localparam int NS  = pwad_pkg::NSTG;
    localparam int TW  = pwad_pkg::CHG_W + $clog2(VEL_WINDOW);
    localparam int RW  = $clog2(VEL_WINDOW);
    localparam int KQW = pwad_pkg::SGAIN_W + TW;
    localparam int KRW = pwad_pkg::SGAIN_W + RW + 1;
    localparam int AW  = KQW + 2;
    localparam int FW  = $clog2(VEL_WINDOW + 1);
    localparam int EW  = pwad_pkg::ERR_W;
    localparam int IW  = pwad_pkg::INTEG_W;
    localparam int CW  = pwad_pkg::CLAMP_W;

    // Configuration registers.
    logic [pwad_pkg::GAIN_W-1:0] r_kp;
    logic [pwad_pkg::GAIN_W-1:0] r_ki;
    logic [pwad_pkg::GAIN_W-1:0] r_kd;
    logic                        r_pone;
    logic                        r_rev;
    pwad_pkg::t_sample           r_min;
    pwad_pkg::t_sample           r_max;
    logic                        r_auto;

    logic                        cfg_wr;
    pwad_pkg::t_cfg_idx          cfg_idx;
    pwad_pkg::t_sample           cfg_s16;
    logic                        clr_cfg;

    // Controller state.
    logic signed [EW-1:0]        r_prev_err;
    logic signed [TW-1:0]        r_total;
    logic [FW-1:0]               r_fill;
    logic signed [IW-1:0]        r_integ;

    // Pipeline control.
    logic [NS:1]                 r_v;
    logic [NS:1]                 adv;
    logic                        acc1;

    // Stage 1 and the history chain.
    logic signed [EW-1:0]        err;
    pwad_pkg::t_change           chg;
    logic signed [TW-1:0]        total_new;
    pwad_pkg::t_change           cell_q [VEL_WINDOW];
    pwad_pkg::t_cell_ctl         cell_ctl;

    logic signed [EW-1:0]        r1_err;
    pwad_pkg::t_change           r1_chg;
    logic signed [TW-1:0]        r1_total;
    logic                        r1_avg;
    logic                        r1_auto;

    // Stage 2: gain products.
    logic signed [pwad_pkg::SGAIN_W-1:0]  kp_s;
    logic signed [pwad_pkg::SGAIN_W-1:0]  ki_s;
    logic signed [pwad_pkg::SGAIN_W-1:0]  kd_s;
    logic signed [pwad_pkg::P_PROD_W-1:0] p_prod;
    logic signed [pwad_pkg::P_PROD_W-1:0] i_prod;
    logic signed [pwad_pkg::C_PROD_W-1:0] c_prod;
    logic signed [pwad_pkg::C_PROD_W-1:0] d_prod;

    logic signed [AW-1:0]                 r2_p;
    logic signed [pwad_pkg::INC_W-1:0]    r2_inc;
    logic signed [AW-1:0]                 r2_draw;
    logic                                 r2_avg;
    logic                                 r2_auto;

    // Stage 3: integral and change-total quotient.
    logic signed [pwad_pkg::SUM_W-1:0]    integ_sum;
    logic signed [CW-1:0]                 integ_c;
    logic signed [TW-1:0]                 qt;
    logic [RW-1:0]                        rt;
    pwad_pkg::t_div_ctl                   div1_ctl;

    logic signed [AW-1:0]                 r3_p;
    logic signed [AW-1:0]                 r3_draw;
    logic                                 r3_avg;
    logic                                 r3_auto;

    // Stages 4 to 6: averaged derivative.
    logic signed [KQW-1:0]                kdqt;
    logic signed [KRW-1:0]                kdrt;
    logic signed [KRW-1:0]                qk;
    pwad_pkg::t_div_ctl                   div2_ctl;

    logic signed [KQW-1:0]                r4_kdqt;
    logic signed [KRW-1:0]                r4_kdrt;
    logic signed [IW-1:0]                 r4_integ;
    logic signed [AW-1:0]                 r4_p;
    logic signed [AW-1:0]                 r4_draw;
    logic                                 r4_avg;
    logic                                 r4_auto;

    logic signed [KQW-1:0]                r5_kdqt;
    logic signed [IW-1:0]                 r5_integ;
    logic signed [AW-1:0]                 r5_p;
    logic signed [AW-1:0]                 r5_draw;
    logic                                 r5_avg;
    logic                                 r5_auto;

    logic signed [KQW-1:0]                r6_kdqt;
    logic signed [IW-1:0]                 r6_integ;
    logic signed [AW-1:0]                 r6_p;
    logic signed [AW-1:0]                 r6_draw;
    logic                                 r6_avg;
    logic                                 r6_auto;

    // Stages 7 and 8: sum, clamp and round.
    logic signed [AW-1:0]                 d_sel;
    logic signed [AW-1:0]                 r7_acc;
    logic                                 r7_auto;
    logic signed [CW-1:0]                 acc_c;
    logic [pwad_pkg::ROUND_W-1:0]         rsum;
    pwad_pkg::t_sample                    r8_drive;
    logic                                 r8_comp;

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;
    assign cfg_idx     = pwad_pkg::t_cfg_idx'(i_cfg.index);
    assign cfg_s16     = i_cfg.data[pwad_pkg::SAMP_W-1:0];
    // Switching from manual to automatic starts from a cleared state.
    assign clr_cfg     = cfg_wr && (cfg_idx == pwad_pkg::CFG_AUTO) && i_cfg.data[0] && !r_auto;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= '0;
            r_ki   <= '0;
            r_kd   <= '0;
            r_pone <= 1'b1;
            r_rev  <= 1'b0;
            r_min  <= pwad_pkg::OUT_MIN_RST;
            r_max  <= pwad_pkg::OUT_MAX_RST;
            r_auto <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                pwad_pkg::CFG_KP:      r_kp   <= i_cfg.data;
                pwad_pkg::CFG_KI:      r_ki   <= i_cfg.data;
                pwad_pkg::CFG_KD:      r_kd   <= i_cfg.data;
                pwad_pkg::CFG_P_ERR:   r_pone <= i_cfg.data[0];
                pwad_pkg::CFG_REVERSE: r_rev  <= i_cfg.data[0];
                pwad_pkg::CFG_OUT_MIN: r_min  <= cfg_s16;
                pwad_pkg::CFG_OUT_MAX: r_max  <= cfg_s16;
                pwad_pkg::CFG_AUTO:    r_auto <= i_cfg.data[0];
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline handshake: a stage takes a word when it is empty or when its
    // own word moves on.
    // ---------------------------------------------------------------------
    always_comb begin
        adv[NS] = !r_v[NS] || o_out.ready;
        for (int k = NS - 1; k >= 1; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign i_in.ready = adv[1];
    assign acc1       = i_in.valid && adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[1]) begin
                r_v[1] <= i_in.valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: error, change and the window of past changes
    // ---------------------------------------------------------------------
    assign err       = EW'(i_in.setpoint) - EW'(i_in.measured);
    assign chg       = pwad_pkg::CHG_W'(err) - pwad_pkg::CHG_W'(r_prev_err);
    assign total_new = r_total + TW'(chg) - TW'(cell_q[VEL_WINDOW-1]);

    assign cell_ctl.shift = acc1 && r_auto;
    assign cell_ctl.clear = clr_cfg || (acc1 && !r_auto);

    for (genvar g = 0; g < VEL_WINDOW; g++) begin : g_hist
        if (g == 0) begin : g_head
            pwad_hcell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (cell_ctl),
                .i_d     (chg),
                .o_q     (cell_q[g])
            );
        end else begin : g_body
            pwad_hcell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (cell_ctl),
                .i_d     (cell_q[g-1]),
                .o_q     (cell_q[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_total    <= '0;
            r_fill     <= '0;
        end else if (clr_cfg || (acc1 && !r_auto)) begin
            r_prev_err <= '0;
            r_total    <= '0;
            r_fill     <= '0;
        end else if (acc1) begin
            r_prev_err <= err;
            r_total    <= total_new;
            if (r_fill != FW'(VEL_WINDOW)) begin
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_err   <= err;
            r1_chg   <= chg;
            r1_total <= total_new;
            r1_avg   <= (r_fill == FW'(VEL_WINDOW));
            r1_auto  <= r_auto;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: gain products
    // ---------------------------------------------------------------------
    assign kp_s   = pwad_pkg::signed_gain(r_kp, r_rev);
    assign ki_s   = pwad_pkg::signed_gain(r_ki, r_rev);
    assign kd_s   = pwad_pkg::signed_gain(r_kd, r_rev);
    assign p_prod = kp_s * r1_err;
    assign i_prod = ki_s * r1_err;
    assign c_prod = kp_s * r1_chg;
    assign d_prod = kd_s * r1_chg;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_p    <= r_pone ? AW'(p_prod) : '0;
            // On measurement, the proportional action moves into the integral.
            r2_inc  <= pwad_pkg::INC_W'(i_prod)
                     - (r_pone ? '0 : pwad_pkg::INC_W'(c_prod));
            r2_draw <= AW'(d_prod);
            r2_avg  <= r1_avg;
            r2_auto <= r1_auto;
        end
    end

    assign div1_ctl.load_a = adv[2];
    assign div1_ctl.load_b = adv[3];

    pwad_fdiv #(
        .XW  (TW),
        .DIV (VEL_WINDOW)
    ) u_div_total (
        .i_clk (i_clk),
        .i_ctl (div1_ctl),
        .i_x   (r1_total),
        .o_q   (qt),
        .o_r   (rt)
    );

    // ---------------------------------------------------------------------
    // Stage 3: integral update with anti-windup clamp
    // ---------------------------------------------------------------------
    assign integ_sum = pwad_pkg::SUM_W'(r_integ) + pwad_pkg::SUM_W'(r2_inc);
    assign integ_c   = pwad_pkg::clamp_q16(CW'(integ_sum), r_min, r_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (adv[3] && r_v[2]) begin
            r_integ <= r2_auto ? integ_c[IW-1:0] : '0;
        end else if (clr_cfg) begin
            r_integ <= '0;
        end else if (cfg_wr && r_auto && (cfg_idx == pwad_pkg::CFG_OUT_MIN)) begin
            r_integ <= IW'(pwad_pkg::clamp_q16(CW'(r_integ), cfg_s16, r_max));
        end else if (cfg_wr && r_auto && (cfg_idx == pwad_pkg::CFG_OUT_MAX)) begin
            r_integ <= IW'(pwad_pkg::clamp_q16(CW'(r_integ), r_min, cfg_s16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_p    <= r2_p;
            r3_draw <= r2_draw;
            r3_avg  <= r2_avg;
            r3_auto <= r2_auto;
        end
    end

    // ---------------------------------------------------------------------
    // Stages 4 to 6: kd * total / window, split as kd * q + kd * r / window
    // ---------------------------------------------------------------------
    assign kdqt = kd_s * qt;
    assign kdrt = kd_s * $signed({1'b0, rt});

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r4_kdqt  <= kdqt;
            r4_kdrt  <= kdrt;
            r4_integ <= r_integ;
            r4_p     <= r3_p;
            r4_draw  <= r3_draw;
            r4_avg   <= r3_avg;
            r4_auto  <= r3_auto;
        end
    end

    assign div2_ctl.load_a = adv[5];
    assign div2_ctl.load_b = adv[6];

    pwad_fdiv #(
        .XW  (KRW),
        .DIV (VEL_WINDOW)
    ) u_div_rem (
        .i_clk (i_clk),
        .i_ctl (div2_ctl),
        .i_x   (r4_kdrt),
        .o_q   (qk),
        .o_r   ()
    );

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r5_kdqt  <= r4_kdqt;
            r5_integ <= r4_integ;
            r5_p     <= r4_p;
            r5_draw  <= r4_draw;
            r5_avg   <= r4_avg;
            r5_auto  <= r4_auto;
        end
        if (adv[6]) begin
            r6_kdqt  <= r5_kdqt;
            r6_integ <= r5_integ;
            r6_p     <= r5_p;
            r6_draw  <= r5_draw;
            r6_avg   <= r5_avg;
            r6_auto  <= r5_auto;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 7: sum of the three terms
    // ---------------------------------------------------------------------
    assign d_sel = r6_avg ? (AW'(r6_kdqt) + AW'(qk)) : r6_draw;

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r7_acc  <= r6_p + AW'(r6_integ) + d_sel;
            r7_auto <= r6_auto;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 8: clamp, round half up, output register
    // ---------------------------------------------------------------------
    assign acc_c = pwad_pkg::clamp_q16(CW'(r7_acc), r_min, r_max);
    assign rsum  = acc_c[pwad_pkg::ROUND_W-1:0] + pwad_pkg::ROUND_W'(pwad_pkg::ROUND_HALF);

    always_ff @(posedge i_clk) begin
        if (adv[NS]) begin
            r8_drive <= r7_auto ? rsum[pwad_pkg::FRAC_W +: pwad_pkg::SAMP_W] : '0;
            r8_comp  <= r7_auto;
        end
    end

    assign o_out.valid    = r_v[NS];
    assign o_out.drive    = r8_drive;
    assign o_out.computed = r8_comp;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pwad_pkg::*;

    localparam int     VEL_WIN        = 8;
    localparam int     RANDOM_SAMPLES = 700;
    localparam int     TIMEOUT_CYCLES = 400000;
    localparam int     MAX_IDLE       = 19;
    localparam longint ONE_Q16        = 65536;

    typedef struct packed {
        t_sample drive;
        logic    computed;
    } drive_word_t;

    typedef struct {
        t_cfg_idx                idx;
        logic [CFG_DATA_W-1:0]   data;
    } reg_write_t;

    logic i_clk;
    logic i_rst_n;

    pwad_in_if  in_if();
    pwad_cfg_if cfg_if();
    pwad_out_if out_if();

    pid_with_averaged_derivative #(.VEL_WINDOW(VEL_WIN)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Controller settings as the block should hold them.
    logic [GAIN_W-1:0] kp_gain_r;
    logic [GAIN_W-1:0] ki_gain_r;
    logic [GAIN_W-1:0] kd_gain_r;
    logic              p_on_err_r;
    logic              reverse_on;
    logic              auto_on;
    t_sample           out_lo;
    t_sample           out_hi;

    // Loop state tracked alongside the block.
    longint last_err;
    longint integ_q16;
    longint chg_hist[VEL_WIN];
    longint chg_total;
    int     hist_slot;
    int     hist_fill;

    drive_word_t predicted_drives[$];
    reg_write_t  queued_writes[$];
    drive_word_t oldest;

    int   feed_max_gap     = 0;
    int   result_max_stall = 0;
    int   result_stall     = 0;
    int   stall_draw;
    bit   feed_held        = 1'b0;
    int   cycle_count      = 0;
    int   mismatches       = 0;
    int   samples_sent     = 0;
    int   regs_written     = 0;
    int   results_checked  = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, predicted_drives.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: after each accepted word, hold ready low for a random stall.
    always @(posedge i_clk) begin
        if (result_stall > 0) begin
            result_stall <= result_stall - 1;
            out_if.ready <= (result_stall == 1);
        end else if (out_if.valid && out_if.ready) begin
            stall_draw = $urandom_range(result_max_stall, 0);
            result_stall <= stall_draw;
            out_if.ready <= (stall_draw == 0);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (predicted_drives.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word, drive %0d computed %0b",
                         $time, out_if.drive, out_if.computed);
            end else begin
                oldest = predicted_drives.pop_front();
                results_checked++;
                if (out_if.drive !== oldest.drive) begin
                    mismatches++;
                    $display("%0t: drive expected %0d actual %0d",
                             $time, oldest.drive, out_if.drive);
                end
                if (out_if.computed !== oldest.computed) begin
                    mismatches++;
                    $display("%0t: computed expected %0b actual %0b",
                             $time, oldest.computed, out_if.computed);
                end
            end
        end
    end

    function automatic longint clamp_to_limits(longint x);
        longint top;
        longint bottom;
        top    = longint'(out_hi) * ONE_Q16;
        bottom = longint'(out_lo) * ONE_Q16;
        if (x > top) begin
            return top;
        end else if (x < bottom) begin
            return bottom;
        end
        return x;
    endfunction

    function automatic void clear_loop_state();
        last_err  = 0;
        integ_q16 = 0;
        foreach (chg_hist[k]) begin
            chg_hist[k] = 0;
        end
        chg_total = 0;
        hist_slot = 0;
        hist_fill = 0;
    endfunction

    function automatic void note_reg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        regs_written++;
        case (idx)
            CFG_KP:      kp_gain_r  = data;
            CFG_KI:      ki_gain_r  = data;
            CFG_KD:      kd_gain_r  = data;
            CFG_P_ERR:   p_on_err_r = data[0];
            CFG_REVERSE: reverse_on = data[0];
            CFG_OUT_MIN: begin
                out_lo = data[SAMP_W-1:0];
                if (auto_on) integ_q16 = clamp_to_limits(integ_q16);
            end
            CFG_OUT_MAX: begin
                out_hi = data[SAMP_W-1:0];
                if (auto_on) integ_q16 = clamp_to_limits(integ_q16);
            end
            CFG_AUTO: begin
                if (data[0] && !auto_on) clear_loop_state();
                auto_on = data[0];
            end
            default: ;
        endcase
    endfunction

    function automatic drive_word_t predict_drive(t_sample sp, t_sample mv);
        drive_word_t word;
        longint      kp;
        longint      ki;
        longint      kd;
        longint      err;
        longint      chg;
        longint      acc;
        longint      dterm;
        longint      num;
        longint      rounded;
        if (!auto_on) begin
            clear_loop_state();
            word.drive    = '0;
            word.computed = 1'b0;
            return word;
        end
        kp = kp_gain_r;
        ki = ki_gain_r;
        kd = kd_gain_r;
        if (reverse_on) begin
            kp = -kp;
            ki = -ki;
            kd = -kd;
        end
        err = longint'(sp) - longint'(mv);
        chg = err - last_err;

        integ_q16 += ki * err;
        if (!p_on_err_r) integ_q16 -= kp * chg;
        integ_q16 = clamp_to_limits(integ_q16);

        acc = p_on_err_r ? kp * err : 0;

        // The newest change replaces the oldest in the running window sum.
        chg_total += chg - chg_hist[hist_slot];
        chg_hist[hist_slot] = chg;
        hist_slot = (hist_slot + 1) % VEL_WIN;

        if (hist_fill < VEL_WIN) begin
            dterm = kd * chg;
            hist_fill++;
        end else begin
            num   = kd * chg_total;
            dterm = num / VEL_WIN;
            if ((num % VEL_WIN) != 0 && num < 0) dterm -= 1;
        end

        acc = clamp_to_limits(acc + integ_q16 + dterm);
        rounded = (acc + ONE_Q16 / 2) >>> FRAC_W;
        last_err = err;

        word.drive    = rounded[SAMP_W-1:0];
        word.computed = 1'b1;
        return word;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.idx  = idx;
        w.data = data;
        queued_writes.push_back(w);
    endtask

    // Lower the sample valid if it is held and wait until every result is back.
    task automatic settle();
        if (feed_held) in_if.valid <= 1'b0;
        feed_held = 1'b0;
        while (predicted_drives.size() != 0) @(posedge i_clk);
    endtask

    // Registers change only with the pipeline empty.
    task automatic apply_regs();
        reg_write_t w;
        bit         wrote;
        wrote = 1'b0;
        settle();
        while (queued_writes.size() != 0) begin
            w = queued_writes.pop_front();
            cfg_if.valid <= 1'b1;
            cfg_if.index <= w.idx;
            cfg_if.data  <= w.data;
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            note_reg_write(w.idx, w.data);
            wrote = 1'b1;
        end
        if (wrote) cfg_if.valid <= 1'b0;
    endtask

    task automatic send_sample(t_sample sp, t_sample mv);
        int gap;
        gap = $urandom_range(feed_max_gap, 0);
        if (gap > 0) begin
            if (feed_held) in_if.valid <= 1'b0;
            feed_held = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.setpoint <= sp;
        in_if.measured <= mv;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predicted_drives.push_back(predict_drive(sp, mv));
        feed_held = 1'b1;
        samples_sent++;
    endtask

    task automatic test_manual_after_reset();
        send_sample(-32768, 32767);
        write_reg(CFG_AUTO, 1);
        apply_regs();
        // Reset gains are zero, so the drive stays at zero once computed.
        send_sample(1000, 0);
    endtask

    task automatic test_gain_extremes();
        feed_max_gap     = MAX_IDLE;
        result_max_stall = MAX_IDLE;
        write_reg(CFG_KP, 24'hFFFFFF);
        write_reg(CFG_OUT_MIN, -32768);
        write_reg(CFG_OUT_MAX, 32767);
        apply_regs();
        send_sample(32767, -32768);
        send_sample(-32768, 32767);
        write_reg(CFG_KI, 24'hFFFFFF);
        write_reg(CFG_KD, 24'hFFFFFF);
        write_reg(CFG_REVERSE, 1);
        apply_regs();
        send_sample(-1, 0);
        send_sample(32767, -32768);
    endtask

    task automatic test_measurement_mode();
        feed_max_gap     = 0;
        result_max_stall = 0;
        write_reg(CFG_KP, 24'h018000);
        write_reg(CFG_KI, 24'h000800);
        write_reg(CFG_KD, 0);
        write_reg(CFG_REVERSE, 0);
        write_reg(CFG_P_ERR, 0);
        write_reg(CFG_OUT_MIN, -1000);
        write_reg(CFG_OUT_MAX, 1000);
        apply_regs();
        send_sample(500, 0);
        send_sample(500, 100);
        send_sample(500, 700);
    endtask

    // Eight raw-change steps, then the window mean takes over.
    task automatic test_derivative_window();
        int trace[10];
        trace = '{0, 300, -200, 1000, 50, -700, 20, 900, -400, 10};
        feed_max_gap = MAX_IDLE;
        write_reg(CFG_KP, 0);
        write_reg(CFG_KI, 0);
        write_reg(CFG_KD, 24'h010000);
        write_reg(CFG_P_ERR, 1);
        write_reg(CFG_OUT_MIN, -32768);
        write_reg(CFG_OUT_MAX, 32767);
        write_reg(CFG_AUTO, 0);
        write_reg(CFG_AUTO, 1);
        apply_regs();
        foreach (trace[k]) begin
            send_sample(0, trace[k]);
        end
    endtask

    task automatic test_limit_writes();
        result_max_stall = MAX_IDLE;
        write_reg(CFG_KD, 0);
        write_reg(CFG_KI, 24'h100000);
        write_reg(CFG_OUT_MIN, -20000);
        write_reg(CFG_OUT_MAX, 20000);
        apply_regs();
        send_sample(2000, 0);
        // The saturated integral must drop to the new upper limit right away.
        write_reg(CFG_OUT_MAX, 300);
        apply_regs();
        send_sample(0, 0);
        // Crossed limits: the upper one is tested first.
        write_reg(CFG_OUT_MIN, 100);
        write_reg(CFG_OUT_MAX, -100);
        apply_regs();
        send_sample(0, 0);
        send_sample(-5000, 5000);
    endtask

    task automatic test_mode_switches();
        feed_max_gap     = 0;
        result_max_stall = 0;
        // Half-step integral exercises rounding of exact halves.
        write_reg(CFG_KI, 24'h008000);
        write_reg(CFG_OUT_MIN, -255);
        write_reg(CFG_OUT_MAX, 255);
        apply_regs();
        send_sample(1, 0);
        send_sample(-2, 0);
        // Upper data bits are don't-care for one-bit registers.
        write_reg(CFG_AUTO, 24'hFFFFFE);
        apply_regs();
        send_sample(5, -5);
        write_reg(CFG_AUTO, 24'h000003);
        write_reg(CFG_P_ERR, 24'h800000);
        apply_regs();
        send_sample(1, 0);
        write_reg(CFG_AUTO, 1);
        apply_regs();
        send_sample(3, 0);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_gain();
        case ($urandom_range(3, 0))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(24'h040000, 0);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_phases();
        int                    goal;
        int                    style;
        int                    count;
        int                    track;
        int                    offs;
        logic [CFG_DATA_W-1:0] word;
        logic [CFG_DATA_W-1:0] lo_word;
        logic [CFG_DATA_W-1:0] hi_word;
        t_sample               lo;
        t_sample               hi;
        t_sample               sp;
        t_sample               mv;
        goal = samples_sent + RANDOM_SAMPLES;
        mv   = 0;
        while (samples_sent < goal) begin
            if ($urandom_range(1, 0)) write_reg(CFG_KP, random_gain());
            if ($urandom_range(1, 0)) write_reg(CFG_KI, random_gain());
            if ($urandom_range(1, 0)) write_reg(CFG_KD, random_gain());
            if ($urandom_range(1, 0)) write_reg(CFG_P_ERR, $urandom);
            if ($urandom_range(1, 0)) write_reg(CFG_REVERSE, $urandom);
            if ($urandom_range(2, 0) != 0) begin
                case ($urandom_range(3, 0))
                    0: begin
                        lo = -32768;
                        hi = 32767;
                    end
                    1: begin
                        offs = $urandom_range(2000, 0);
                        lo   = -offs;
                        hi   = $urandom_range(2000, 0);
                    end
                    2: begin
                        lo = $urandom;
                        hi = $urandom;
                    end
                    default: begin
                        lo = $urandom;
                        hi = lo;
                    end
                endcase
                lo_word = $urandom;
                hi_word = $urandom;
                lo_word[SAMP_W-1:0] = lo;
                hi_word[SAMP_W-1:0] = hi;
                if ($urandom_range(1, 0)) begin
                    write_reg(CFG_OUT_MIN, lo_word);
                    write_reg(CFG_OUT_MAX, hi_word);
                end else begin
                    write_reg(CFG_OUT_MAX, hi_word);
                    write_reg(CFG_OUT_MIN, lo_word);
                end
            end
            if ($urandom_range(3, 0) != 0) begin
                word    = $urandom;
                word[0] = ($urandom_range(6, 0) != 0);
                write_reg(CFG_AUTO, word);
            end
            apply_regs();

            feed_max_gap     = ($urandom_range(3, 0) == 0) ? 0 : MAX_IDLE;
            result_max_stall = ($urandom_range(3, 0) == 0) ? 0 : MAX_IDLE;
            style = $urandom_range(2, 0);
            count = $urandom_range(50, 10);
            sp    = $urandom;
            track = sp;
            repeat (count) begin
                if ($urandom_range(9, 0) == 0) begin
                    sp = $urandom;
                    mv = $urandom;
                end else begin
                    case (style)
                        0: begin
                            sp = $urandom;
                            mv = $urandom;
                        end
                        1: begin
                            // Slowly wandering setpoint with a small tracking error.
                            track += int'($urandom_range(200, 0)) - 100;
                            sp     = track;
                            offs   = int'($urandom_range(64, 0)) - 32;
                            mv     = int'(sp) + offs;
                        end
                        default: begin
                            // Setpoint steps with a first-order lag on the measurement.
                            if ($urandom_range(7, 0) == 0) begin
                                track = int'($urandom_range(60000, 0)) - 30000;
                            end
                            sp = track;
                            mv = int'(mv) + (int'(sp) - int'(mv)) / 4;
                        end
                    endcase
                end
                send_sample(sp, mv);
                if ($urandom_range(59, 0) == 0) settle();
            end
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.setpoint = '0;
        in_if.measured = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = CFG_KP;
        cfg_if.data    = '0;
        out_if.ready   = 1'b0;

        kp_gain_r  = '0;
        ki_gain_r  = '0;
        kd_gain_r  = '0;
        p_on_err_r = 1'b1;
        reverse_on = 1'b0;
        auto_on    = 1'b0;
        out_lo     = OUT_MIN_RST;
        out_hi     = OUT_MAX_RST;
        clear_loop_state();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_manual_after_reset();
        test_gain_extremes();
        test_measurement_mode();
        test_derivative_window();
        test_limit_writes();
        test_mode_switches();
        test_random_phases();

        settle();
        repeat (2 * NSTG) @(posedge i_clk);

        $display("Ran %0d samples through manual and automatic modes with %0d register writes;",
                 samples_sent, regs_written);
        $display("%0d results checked over gain, limit and derivative-window settings.",
                 results_checked);
        if (mismatches == 0 && predicted_drives.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: sim.f
design/pwad_pkg.sv
design/pwad_ifs.sv
design/pwad_hcell.sv
design/pwad_fdiv.sv
design/pid_with_averaged_derivative.sv
verif/tb_top.sv
